>>> rtl/jhbp_pkg.sv
`default_nettype none

package jhbp_pkg;

   // Input item modes
   typedef enum logic [1:0] {
      MODE_LOAD_DC = 2'd0,
      MODE_LOAD_AC = 2'd1,
      MODE_ENC_DC  = 2'd2,
      MODE_ENC_AC  = 2'd3
   } mode_type;

   // Fixed widths of the stream and the tables
   localparam int BYTE_W         = 8;
   localparam int CODE_W         = 16;
   localparam int LEN_W          = 5;
   localparam int CAT_W          = 4;
   localparam int AC_TABLE_DEPTH = 256;
   localparam int AC_IDX_W       = $clog2(AC_TABLE_DEPTH);
   localparam int SYM_BITS_W     = 32;
   localparam int NBITS_W        = 6;
   localparam int ACC_W          = 38;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_W-1:0]  MAX_CODE_LEN  = 5'd16;
   localparam logic [BYTE_W-1:0] STUFF_TRIGGER = 8'hff;
   localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;

   // One coded symbol: codeword and amplitude bits, right aligned
   typedef struct packed {
      logic [SYM_BITS_W-1:0] bits;
      logic [NBITS_W-1:0]    nbits;
   } sym_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

>>> rtl/jpeg_huffman_bit_packer_core.sv
// JPEG baseline Huffman bit packer.
// Request channel (req_*): one beat per item. Modes 0 and 1 load a DC or AC
// table entry (codeword right aligned, length saturated to 16); modes 2 and 3
// encode a DC category or an AC run/category symbol followed by the low
// category bits of the amplitude.
// Response channel (rsp_*): one beat per coded byte, 0x00 stuffed after each
// 0xFF, rsp_last set on the final byte an encode item causes. Encodes that
// complete no byte give no beats; no padding flush is ever made.
// An encode beat passes the lookup stage, the queue, the accumulator and the
// output register before its first byte appears. Throughput: the front takes
// one item per cycle, while req_ready is high, into a two-entry queue;
// the back merges one symbol at a time, emits its bytes and takes the next
// symbol only once the last byte of the current one is out.
// Load items never touch the queue. Reset (synchronous) clears the DC table,
// the AC valid bits, the pending bits and all control.
// A stalled receiver holds the output register; the back then stops, the
// queue fills and req_ready drops once the lookup stage cannot drain.
`default_nettype none

module jpeg_huffman_bit_packer_core #(
   parameter int DC_TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_table_index,
   input  wire logic [15:0] req_code_bits,
   input  wire logic [4:0]  req_code_len,
   input  wire logic [3:0]  req_run_length,
   input  wire logic [3:0]  req_category,
   input  wire logic [15:0] req_amplitude,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);
   import jhbp_pkg::*;

   logic         push;
   logic         pop;
   sym_type      push_entry;
   sym_type      pop_entry;
   q_status_type q_status;

   // Accept, look up and format symbols
   jhbp_front #(
      .DC_TABLE_DEPTH (DC_TABLE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_table_index (req_table_index),
      .req_code_bits   (req_code_bits),
      .req_code_len    (req_code_len),
      .req_run_length  (req_run_length),
      .req_category    (req_category),
      .req_amplitude   (req_amplitude),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   // Decouple lookup from packing
   jhbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // Pack bits into bytes and stuff
   jhbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

>>> rtl/jhbp_queue.sv
`default_nettype none

module jhbp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire jhbp_pkg::sym_type     push_entry,
   input  wire logic                  pop,
   output jhbp_pkg::sym_type          pop_entry,
   output jhbp_pkg::q_status_type     status
);
   import jhbp_pkg::*;

   sym_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry on push
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = entry_ff[rd_ptr_ff];
   assign status    = '{full:  (count_ff == QCNT_W'(QUEUE_DEPTH)),
                        empty: (count_ff == '0)};

endmodule

`default_nettype wire

>>> rtl/jhbp_front.sv
`default_nettype none

module jhbp_front #(
   parameter int DC_TABLE_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_mode,
   input  wire logic [7:0]            req_table_index,
   input  wire logic [15:0]           req_code_bits,
   input  wire logic [4:0]            req_code_len,
   input  wire logic [3:0]            req_run_length,
   input  wire logic [3:0]            req_category,
   input  wire logic [15:0]           req_amplitude,
   input  wire jhbp_pkg::q_status_type q_status,
   output logic                       push,
   output jhbp_pkg::sym_type          push_entry
);
   import jhbp_pkg::*;

   localparam int DC_IDX_W = $clog2(DC_TABLE_DEPTH);
   localparam logic [CAT_W:0] DC_DEPTH_L = (CAT_W + 1)'(DC_TABLE_DEPTH);

   // Tables: DC in flip-flops, AC in a memory with valid bits
   logic [CODE_W-1:0]        dc_cw_ff  [DC_TABLE_DEPTH];
   logic [LEN_W-1:0]         dc_len_ff [DC_TABLE_DEPTH];
   logic [CODE_W+LEN_W-1:0]  ac_mem    [AC_TABLE_DEPTH];
   logic [AC_TABLE_DEPTH-1:0] ac_valid_ff;

   // Lookup stage
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_is_ac_ff;
   logic                     s1_ac_hit_ff;
   logic [CODE_W+LEN_W-1:0]  s1_ac_rd_ff;
   logic [CODE_W-1:0]        s1_dc_cw_ff;
   logic [LEN_W-1:0]         s1_dc_len_ff;
   logic [CAT_W-1:0]         s1_cat_ff;
   logic [CODE_W-1:0]        s1_amp_ff;

   logic                     req_fire;
   logic [LEN_W-1:0]         len_sat;
   logic [AC_IDX_W-1:0]      ac_sym;
   logic                     load_dc_ok;
   logic                     enc_dc_ok;
   mode_type                 mode;

   logic [CODE_W-1:0]        cw_sel;
   logic [LEN_W-1:0]         len_sel;
   logic [CODE_W:0]          cw_mask;
   logic [CODE_W:0]          amp_mask;
   logic [CODE_W-1:0]        cw_m;
   logic [CODE_W-1:0]        amp_m;

   assign mode       = mode_type'(req_mode);
   assign push       = s1_valid_ff && !q_status.full;
   assign req_ready  = !s1_valid_ff || !q_status.full;
   assign req_fire   = req_valid && req_ready;
   assign len_sat    = (req_code_len > MAX_CODE_LEN) ? MAX_CODE_LEN : req_code_len;
   assign ac_sym     = {req_run_length, req_category};
   assign load_dc_ok = ({1'b0, req_table_index[CAT_W-1:0]} < DC_DEPTH_L);
   assign enc_dc_ok  = ({1'b0, req_category} < DC_DEPTH_L);

   // Write the DC table on a load beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DC_TABLE_DEPTH; i++) begin
            dc_cw_ff[i]  <= '0;
            dc_len_ff[i] <= '0;
         end
      end else if (req_fire && mode == MODE_LOAD_DC && load_dc_ok) begin
         dc_cw_ff[req_table_index[DC_IDX_W-1:0]]  <= req_code_bits;
         dc_len_ff[req_table_index[DC_IDX_W-1:0]] <= len_sat;
      end
   end

   // AC memory: write on load, registered read on encode
   always_ff @(posedge clock) begin
      if (req_fire && mode == MODE_LOAD_AC) begin
         ac_mem[req_table_index] <= {len_sat, req_code_bits};
      end
      if (req_fire && mode == MODE_ENC_AC) begin
         s1_ac_rd_ff <= ac_mem[ac_sym];
      end
   end

   // Mark AC entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ac_valid_ff <= '0;
      end else if (req_fire && mode == MODE_LOAD_AC) begin
         ac_valid_ff[req_table_index] <= 1'b1;
      end
   end

   // Capture the encode beat for the lookup stage
   always_comb begin
      s1_valid_in = s1_valid_ff && !push;
      if (req_fire) begin
         s1_valid_in = (mode == MODE_ENC_DC) || (mode == MODE_ENC_AC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_is_ac_ff  <= (mode == MODE_ENC_AC);
         s1_ac_hit_ff <= ac_valid_ff[ac_sym];
         s1_cat_ff    <= req_category;
         s1_amp_ff    <= req_amplitude;
         if (enc_dc_ok) begin
            s1_dc_cw_ff  <= dc_cw_ff[req_category[DC_IDX_W-1:0]];
            s1_dc_len_ff <= dc_len_ff[req_category[DC_IDX_W-1:0]];
         end else begin
            s1_dc_cw_ff  <= '0;
            s1_dc_len_ff <= '0;
         end
      end
   end

   // Pick the codeword, mask it and the amplitude, join them
   always_comb begin
      if (s1_is_ac_ff) begin
         cw_sel  = s1_ac_hit_ff ? s1_ac_rd_ff[CODE_W-1:0] : '0;
         len_sel = s1_ac_hit_ff ? s1_ac_rd_ff[CODE_W+LEN_W-1:CODE_W] : '0;
      end else begin
         cw_sel  = s1_dc_cw_ff;
         len_sel = s1_dc_len_ff;
      end
      cw_mask  = ((CODE_W + 1)'(1) << len_sel) - 1'b1;
      amp_mask = ((CODE_W + 1)'(1) << s1_cat_ff) - 1'b1;
      cw_m     = cw_sel & cw_mask[CODE_W-1:0];
      amp_m    = s1_amp_ff & amp_mask[CODE_W-1:0];
      push_entry.bits  = ({{(SYM_BITS_W - CODE_W){1'b0}}, cw_m} << s1_cat_ff)
                         | {{(SYM_BITS_W - CODE_W){1'b0}}, amp_m};
      push_entry.nbits = {1'b0, len_sel} + {2'b00, s1_cat_ff};
   end

endmodule

`default_nettype wire

>>> rtl/jhbp_back.sv
`default_nettype none

module jhbp_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire jhbp_pkg::q_status_type q_status,
   input  wire jhbp_pkg::sym_type      pop_entry,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last
);
   import jhbp_pkg::*;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_EMIT  = 3'b010,
      BK_STUFF = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [NBITS_W-1:0]  n_ff, n_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;

   logic                out_free;
   logic [ACC_W-1:0]    shifted;
   logic [BYTE_W-1:0]   next_byte;
   logic [NBITS_W-1:0]  n_rem;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign n_rem     = n_ff - NBITS_W'(BYTE_W);
   assign shifted   = acc_ff >> n_rem;
   assign next_byte = shifted[BYTE_W-1:0];

   // Merge symbols into the accumulator and peel off bytes, MSB first
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      n_in         = n_ff;
      pop          = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               acc_in   = (acc_ff << pop_entry.nbits)
                          | {{(ACC_W - SYM_BITS_W){1'b0}}, pop_entry.bits};
               n_in     = n_ff + pop_entry.nbits;
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (n_ff < NBITS_W'(BYTE_W)) begin
               state_in = BK_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = next_byte;
               out_last_in  = (next_byte != STUFF_TRIGGER) && (n_rem < NBITS_W'(BYTE_W));
               n_in         = n_rem;
               if (next_byte == STUFF_TRIGGER) begin
                  state_in = BK_STUFF;
               end else if (n_rem < NBITS_W'(BYTE_W)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_STUFF: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = STUFF_BYTE;
               out_last_in  = (n_ff < NBITS_W'(BYTE_W));
               state_in     = (n_ff < NBITS_W'(BYTE_W)) ? BK_IDLE : BK_EMIT;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         acc_ff       <= '0;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         n_ff         <= n_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the output beat until taken
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

endmodule

`default_nettype wire

>>> rtl/jhbp_checker.sv
`default_nettype none

module jhbp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last
);

   // Hold a stalled request beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("stalled request beat dropped");

   // Hold a stalled response beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled response beat changed");

   // A 0xFF byte never closes an item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte == 8'hff |-> !rsp_last)
      else $error("0xff marked as last");

   // A taken 0xFF is followed at once by the stuffed zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_out_byte == 8'hff |=> rsp_valid && rsp_out_byte == 8'h00)
      else $error("missing stuffed zero");

   // No response beat straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind jpeg_huffman_bit_packer_core jhbp_checker u_jhbp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);

`default_nettype wire

>>> verif/jhbp_stream_checker.sv
`default_nettype none

module jhbp_stream_checker #(
   parameter int DC_TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_table_index,
   input  wire logic [15:0] req_code_bits,
   input  wire logic [4:0]  req_code_len,
   input  wire logic [3:0]  req_run_length,
   input  wire logic [3:0]  req_category,
   input  wire logic [15:0] req_amplitude,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_last,
   output int               mismatch_total,
   output int               bytes_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import jhbp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } coded_beat_type;

   // Bytes still owed by the block, oldest first
   coded_beat_type expected_stream[$];

   // Own copy of the code tables and the pending bits
   logic [15:0] dc_code [16];
   logic [4:0]  dc_size [16];
   logic [15:0] ac_code [256];
   logic [4:0]  ac_size [256];
   logic [6:0]  held_bits;
   logic [3:0]  held_count;

   initial begin
      mismatch_total = 0;
      bytes_pending  = 0;
   end

   task automatic note_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      mismatch_total = mismatch_total + 1;
      if (mismatch_total <= 10)
         $display("%0t: mismatch on %s: expected %02h, actual %02h", $realtime, what,
                  want, got);
   endtask

   // Apply one accepted beat: update a table, or pack a symbol into bytes
   task automatic predict_item(input mode_type m, input logic [7:0] idx,
                               input logic [15:0] cw_in, input logic [4:0] len_in,
                               input logic [3:0] run, input logic [3:0] cat,
                               input logic [15:0] amp);
      logic [4:0]  len_sat;
      logic [7:0]  sym;
      logic [15:0] cw;
      int unsigned len;
      int unsigned n;
      logic [63:0] acc;
      logic [63:0] slice;
      logic [7:0]  produced [8];
      int          k;
      coded_beat_type beat;
      len_sat = (len_in > MAX_CODE_LEN) ? MAX_CODE_LEN : len_in;
      sym = {run, cat};
      case (m)
         MODE_LOAD_DC: begin
            if (idx[3:0] < DC_TABLE_DEPTH) begin
               dc_code[idx[3:0]] = cw_in;
               dc_size[idx[3:0]] = len_sat;
            end
         end
         MODE_LOAD_AC: begin
            ac_code[idx] = cw_in;
            ac_size[idx] = len_sat;
         end
         default: begin
            // Look up the codeword; DC categories beyond the table send no code
            if (m == MODE_ENC_DC) begin
               if (cat < DC_TABLE_DEPTH) begin
                  cw  = dc_code[cat];
                  len = dc_size[cat];
               end else begin
                  cw  = '0;
                  len = 0;
               end
            end else begin
               cw  = ac_code[sym];
               len = ac_size[sym];
            end
            // Append codeword then amplitude bits, MSB first
            acc = {57'd0, held_bits};
            n   = held_count;
            acc = (acc << len) | ({48'd0, cw} & ((64'd1 << len) - 64'd1));
            n   = n + len;
            acc = (acc << cat) | ({48'd0, amp} & ((64'd1 << cat) - 64'd1));
            n   = n + cat;
            // Emit whole bytes, stuffing a zero after each 0xFF
            k = 0;
            while (n >= 8) begin
               slice = acc >> (n - 8);
               n = n - 8;
               produced[k] = slice[7:0];
               k = k + 1;
               if (slice[7:0] == STUFF_TRIGGER) begin
                  produced[k] = STUFF_BYTE;
                  k = k + 1;
               end
            end
            for (int i = 0; i < k; i++) begin
               beat.data = produced[i];
               beat.last = (i == k - 1);
               expected_stream.push_back(beat);
            end
            // Hold the leftover bits for the next symbol
            slice = acc & ((64'd1 << n) - 64'd1);
            held_bits  = slice[6:0];
            held_count = n[3:0];
         end
      endcase
   endtask

   // Sample both channels mid-cycle, when inputs and outputs have settled
   always @(negedge clock) begin
      coded_beat_type want;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            dc_code[i] = '0;
            dc_size[i] = '0;
         end
         for (int i = 0; i < 256; i++) begin
            ac_code[i] = '0;
            ac_size[i] = '0;
         end
         held_bits  = '0;
         held_count = '0;
         expected_stream.delete();
         bytes_pending = 0;
      end else begin
         // Compare the outgoing beat with the oldest expected byte
         if (rsp_valid && rsp_ready) begin
            if (expected_stream.size() == 0) begin
               note_mismatch("unexpected beat", 8'h00, rsp_out_byte);
            end else begin
               want = expected_stream.pop_front();
               if (rsp_out_byte !== want.data)
                  note_mismatch("out_byte", want.data, rsp_out_byte);
               if (rsp_last !== want.last)
                  note_mismatch("last", {7'd0, want.last}, {7'd0, rsp_last});
            end
         end
         if (req_valid && req_ready)
            predict_item(mode_type'(req_mode), req_table_index, req_code_bits,
                         req_code_len, req_run_length, req_category, req_amplitude);
         bytes_pending = expected_stream.size();
      end
   end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import jhbp_pkg::*;

   localparam int DC_DEPTH     = 16;
   localparam int RANDOM_ITEMS = 280;
   localparam int LIMIT_CYCLES = 200000;
   localparam int TAIL_CYCLES  = 32;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode        = MODE_LOAD_DC;
   logic [7:0]  req_table_index = '0;
   logic [15:0] req_code_bits   = '0;
   logic [4:0]  req_code_len    = '0;
   logic [3:0]  req_run_length  = '0;
   logic [3:0]  req_category    = '0;
   logic [15:0] req_amplitude   = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   int          mismatch_total;
   int          bytes_pending;
   int          cycle_count     = 0;
   logic        idle_on         = 1'b1;
   int          stall_request   = 0;
   int          stall_left      = 0;
   logic [7:0]  ac_known [$];

   jpeg_huffman_bit_packer_core #(
      .DC_TABLE_DEPTH(DC_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_table_index(req_table_index),
      .req_code_bits  (req_code_bits),
      .req_code_len   (req_code_len),
      .req_run_length (req_run_length),
      .req_category   (req_category),
      .req_amplitude  (req_amplitude),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

   jhbp_stream_checker #(
      .DC_TABLE_DEPTH(DC_DEPTH)
   ) stream_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_table_index(req_table_index),
      .req_code_bits  (req_code_bits),
      .req_code_len   (req_code_len),
      .req_run_length (req_run_length),
      .req_category   (req_category),
      .req_amplitude  (req_amplitude),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .mismatch_total (mismatch_total),
      .bytes_pending  (bytes_pending)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Byte receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (stall_left == 0 && stall_request != 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(0, 99) < 10);
      end
   end

   // Offer one beat, maybe after a short gap, and hold it until accepted
   task automatic offer_item(input mode_type m, input logic [7:0] idx,
                             input logic [15:0] cw, input logic [4:0] len,
                             input logic [3:0] run, input logic [3:0] cat,
                             input logic [15:0] amp);
      int unsigned gap;
      gap = (idle_on && $urandom_range(0, 99) < 10) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= m;
      req_table_index <= idx;
      req_code_bits   <= cw;
      req_code_len    <= len;
      req_run_length  <= run;
      req_category    <= cat;
      req_amplitude   <= amp;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // Table load; fields the load ignores still carry random values
   task automatic load_entry(input mode_type m, input logic [7:0] idx,
                             input logic [15:0] cw, input logic [4:0] len);
      logic [15:0] amp;
      amp = 16'($urandom);
      if (m == MODE_LOAD_AC)
         ac_known.push_back(idx);
      offer_item(m, idx, cw, len, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 amp);
   endtask

   // Symbol encode; table fields carry random values
   task automatic encode_symbol(input mode_type m, input logic [3:0] run,
                                input logic [3:0] cat, input logic [15:0] amp);
      logic [15:0] cw;
      cw = 16'($urandom);
      offer_item(m, 8'($urandom_range(0, 255)), cw, 5'($urandom_range(0, 31)), run, cat,
                 amp);
   endtask

   // Drop valid and wait until the block owes nothing
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
   endtask

   // One random item: mostly encodes against loaded entries, some loads
   task automatic random_item();
      int unsigned pick;
      logic [15:0] cw;
      logic [4:0]  len;
      logic [15:0] amp;
      logic [7:0]  sym;
      pick = $urandom_range(0, 99);
      cw   = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      amp  = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
      case ($urandom_range(0, 9))
         0:       len = 5'd0;
         1:       len = 5'($urandom_range(17, 31));
         default: len = 5'($urandom_range(1, 16));
      endcase
      if (ac_known.size() != 0 && $urandom_range(0, 3) != 0)
         sym = ac_known[$urandom_range(0, ac_known.size() - 1)];
      else
         sym = 8'($urandom_range(0, 255));
      if (pick < 8)
         load_entry(MODE_LOAD_DC, 8'($urandom_range(0, 255)), cw, len);
      else if (pick < 16)
         load_entry(MODE_LOAD_AC, 8'($urandom_range(0, 255)), cw, len);
      else if (pick < 50)
         encode_symbol(MODE_ENC_DC, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       amp);
      else
         encode_symbol(MODE_ENC_AC, sym[7:4], sym[3:0], amp);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Encodes against the cleared tables: only amplitude bits go out
      encode_symbol(MODE_ENC_DC, 4'd0, 4'd0, 16'hffff);
      encode_symbol(MODE_ENC_DC, 4'd9, 4'd15, 16'hffff);
      encode_symbol(MODE_ENC_AC, 4'd0, 4'd0, 16'h0000);

      // Loads: upper index nibble ignored for DC, lengths above 16 saturate
      load_entry(MODE_LOAD_DC, 8'h00, 16'h0000, 5'd2);
      load_entry(MODE_LOAD_DC, 8'hf3, 16'h0002, 5'd3);
      load_entry(MODE_LOAD_DC, 8'h0f, 16'hffff, 5'd31);
      load_entry(MODE_LOAD_DC, 8'h07, 16'h0aaa, 5'd17);
      load_entry(MODE_LOAD_DC, 8'h05, 16'h1234, 5'd0);
      load_entry(MODE_LOAD_AC, 8'h00, 16'h000a, 5'd4);
      load_entry(MODE_LOAD_AC, 8'hf0, 16'h07f9, 5'd11);
      load_entry(MODE_LOAD_AC, 8'hff, 16'hffff, 5'd16);
      load_entry(MODE_LOAD_AC, 8'h01, 16'h0000, 5'd2);

      // All-ones symbols: long runs of stuffed bytes, the most beats per item
      encode_symbol(MODE_ENC_DC, 4'd0, 4'd15, 16'h7fff);
      encode_symbol(MODE_ENC_AC, 4'd15, 4'd15, 16'hffff);
      // End of block, zero run, category zero, zero-length entry
      encode_symbol(MODE_ENC_AC, 4'd0, 4'd0, 16'hffff);
      encode_symbol(MODE_ENC_AC, 4'd15, 4'd0, 16'h0000);
      encode_symbol(MODE_ENC_DC, 4'd3, 4'd0, 16'h0000);
      encode_symbol(MODE_ENC_DC, 4'd2, 4'd5, 16'h0015);
      encode_symbol(MODE_ENC_DC, 4'd1, 4'd3, 16'h0000);
      encode_symbol(MODE_ENC_AC, 4'd0, 4'd1, 16'h0001);
      encode_symbol(MODE_ENC_DC, 4'd6, 4'd7, 16'h5555);
      // Unloaded AC entry, then load it with its top code bit set
      encode_symbol(MODE_ENC_AC, 4'd8, 4'd10, 16'h8000);
      load_entry(MODE_LOAD_AC, 8'h8a, 16'h8000, 5'd16);
      encode_symbol(MODE_ENC_AC, 4'd8, 4'd10, 16'h03ff);

      // Random part: table preload first, then a mix of encodes and loads
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 60)
            stall_request = 300;
         if (i == 150)
            wait_drained();
         if (i == 180)
            idle_on <= 1'b0;
         if (i == 240)
            idle_on <= 1'b1;
         if (i < 16)
            load_entry(MODE_LOAD_DC, {4'($urandom_range(0, 15)), 4'(i)},
                       16'($urandom), 5'($urandom_range(1, 16)));
         else if (i < 36)
            load_entry(MODE_LOAD_AC, 8'($urandom_range(0, 255)), 16'($urandom),
                       5'($urandom_range(1, 16)));
         else
            random_item();
      end

      // Drain, allow the pipeline to settle, give the verdict
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && bytes_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
